// File: rtl/npc_pkg.sv
// Shared types, constants and the palette ROM of the nearest palette color block.
// Used by every module of the block and by its checker; depends on nothing.
`default_nettype none

package npc_pkg;

    // Number of palette entries that take part in the search (2 to 16).
    localparam int NUM_COLORS = 15;
    // Rows held in the palette ROM.
    localparam int ROM_ROWS   = 16;

    localparam int CHAN_W     = 8;
    localparam int SQ_W       = 2 * CHAN_W;
    // Sum of three squares of 8-bit differences fits in 18 bits.
    localparam int DIST_W     = SQ_W + 2;
    localparam int IDX_W      = 4;

    // Comparison tree: leaves padded up to a power of two.
    localparam int TREE_LEVELS = $clog2(NUM_COLORS);
    localparam int TREE_LEAVES = 1 << TREE_LEVELS;

    typedef logic [CHAN_W-1:0] chan_t;
    typedef logic [DIST_W-1:0] dist_t;
    typedef logic [IDX_W-1:0]  idx_t;

    typedef struct packed {
        chan_t r;
        chan_t g;
        chan_t b;
    } rgb_t;

    typedef dist_t [NUM_COLORS-1:0] dist_vec_t;

    // Basic palette colors; the last row is reached only with sixteen colors.
    localparam rgb_t PALETTE_ROM [ROM_ROWS] = '{
        '{8'd0,   8'd0,   8'd0  },
        '{8'd62,  8'd184, 8'd73 },
        '{8'd116, 8'd208, 8'd125},
        '{8'd89,  8'd85,  8'd224},
        '{8'd128, 8'd118, 8'd241},
        '{8'd185, 8'd94,  8'd81 },
        '{8'd101, 8'd219, 8'd239},
        '{8'd219, 8'd101, 8'd89 },
        '{8'd255, 8'd137, 8'd125},
        '{8'd204, 8'd195, 8'd94 },
        '{8'd222, 8'd208, 8'd135},
        '{8'd58,  8'd162, 8'd65 },
        '{8'd183, 8'd102, 8'd181},
        '{8'd204, 8'd204, 8'd204},
        '{8'd255, 8'd255, 8'd255},
        '{8'd44,  8'd42,  8'd112}
    };

    // Square of the absolute difference of two channel values.
    function automatic logic [SQ_W-1:0] sq_diff(input chan_t a, input chan_t b);
        chan_t d;
        d = (a >= b) ? (a - b) : (b - a);
        return {{CHAN_W{1'b0}}, d} * {{CHAN_W{1'b0}}, d};
    endfunction

endpackage

`default_nettype wire

// File: rtl/npc_dist.sv
// Squared Euclidean distance from one pixel to every searched palette color.
// Depends on npc_pkg for the palette ROM and the distance type.
`default_nettype none

module npc_dist (
    input  wire npc_pkg::chan_t     red,
    input  wire npc_pkg::chan_t     green,
    input  wire npc_pkg::chan_t     blue,
    output npc_pkg::dist_vec_t      sq_dist
);
    import npc_pkg::*;

    // One independent distance unit for each searched palette entry.
    always_comb
    begin
        for (int i = 0; i < NUM_COLORS; i++)
        begin
            sq_dist[i] = {2'b00, sq_diff(red,   PALETTE_ROM[i].r)}
                       + {2'b00, sq_diff(green, PALETTE_ROM[i].g)}
                       + {2'b00, sq_diff(blue,  PALETTE_ROM[i].b)};
        end
    end

endmodule

`default_nettype wire

// File: rtl/npc_argmin.sv
// Comparison tree that picks the index of the smallest distance.
// Depends on npc_pkg; on equal distances the lower index is kept.
`default_nettype none

module npc_argmin (
    input  wire npc_pkg::dist_vec_t sq_dist,
    output npc_pkg::idx_t           best_index
);
    import npc_pkg::*;

    dist_t node_dist [TREE_LEVELS+1][TREE_LEAVES];
    idx_t  node_idx  [TREE_LEVELS+1][TREE_LEAVES];
    logic  node_vld  [TREE_LEVELS+1][TREE_LEAVES];

    // Leaves, then one level of pairwise compares per tree level.
    always_comb
    begin
        for (int j = 0; j < TREE_LEAVES; j++)
        begin
            node_idx[0][j] = IDX_W'(j);
            if (j < NUM_COLORS)
            begin
                node_dist[0][j] = sq_dist[j];
                node_vld[0][j]  = 1'b1;
            end
            else
            begin
                node_dist[0][j] = '0;
                node_vld[0][j]  = 1'b0;
            end
        end
        for (int l = 1; l <= TREE_LEVELS; l++)
        begin
            for (int j = 0; j < TREE_LEAVES; j++)
            begin
                node_dist[l][j] = '0;
                node_idx[l][j]  = '0;
                node_vld[l][j]  = 1'b0;
            end
            for (int j = 0; j < (TREE_LEAVES >> l); j++)
            begin
                // The right branch wins only when strictly closer.
                if (node_vld[l-1][2*j+1] &&
                    (!node_vld[l-1][2*j] ||
                     node_dist[l-1][2*j+1] < node_dist[l-1][2*j]))
                begin
                    node_dist[l][j] = node_dist[l-1][2*j+1];
                    node_idx[l][j]  = node_idx[l-1][2*j+1];
                end
                else
                begin
                    node_dist[l][j] = node_dist[l-1][2*j];
                    node_idx[l][j]  = node_idx[l-1][2*j];
                end
                node_vld[l][j] = node_vld[l-1][2*j] | node_vld[l-1][2*j+1];
            end
        end
    end

    assign best_index = node_idx[TREE_LEVELS][0];

endmodule

`default_nettype wire

// File: rtl/nearest_palette_color_rgb.sv
// Top level of the nearest palette color block: input register, distance
// units, comparison tree and result register. Depends on npc_pkg, npc_dist
// and npc_argmin.
//
// Usage:
// A pixel request (red, green, blue) is offered with pixel_valid and taken at
// a rising edge where pixel_valid is high and pixel_stall is low. The block
// answers each pixel with one result request carrying color_index, the index
// of the closest basic palette color, lowest index on equal distances.
// color_index is held with result_valid until a rising edge with result_stall
// low.
// The accepting edge loads the input register; from there the pixel moves
// through the distance units and the comparison tree into the result
// register once that register is empty or being drained.
// Throughput is one pixel per cycle while the receiver does not stall; the
// figure is set by that single register-to-register pass.
// When the receiver stalls, the result register holds, the input register
// holds the next pixel, and pixel_stall rises once both are full.
// Reset clears both valid flags; no pixel or result survives it.
`default_nettype none

module nearest_palette_color_rgb (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     pixel_valid,
    output logic                    pixel_stall,
    input  wire npc_pkg::chan_t     red,
    input  wire npc_pkg::chan_t     green,
    input  wire npc_pkg::chan_t     blue,
    output logic                    result_valid,
    input  wire                     result_stall,
    output npc_pkg::idx_t           color_index
);
    import npc_pkg::*;

    logic      pix_valid_reg;
    rgb_t      pix_reg;
    logic      res_valid_reg;
    idx_t      color_index_reg;
    idx_t      color_index_next;
    dist_vec_t sq_dist;
    logic      res_load;
    logic      pix_load;

    // The result register loads whenever it is empty or being drained.
    assign res_load    = !res_valid_reg || !result_stall;
    assign pixel_stall = pix_valid_reg && !res_load;
    assign pix_load    = pixel_valid && !pixel_stall;

    // Input register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_valid_reg <= 1'b0;
        end
        else if (res_load || !pix_valid_reg)
        begin
            pix_valid_reg <= pixel_valid;
        end
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (pix_load)
        begin
            pix_reg <= '{r: red, g: green, b: blue};
        end
    end

    // Distances to every searched palette color.
    npc_dist u_dist (
        .red     (pix_reg.r),
        .green   (pix_reg.g),
        .blue    (pix_reg.b),
        .sq_dist (sq_dist)
    );

    // Index of the smallest distance.
    npc_argmin u_argmin (
        .sq_dist    (sq_dist),
        .best_index (color_index_next)
    );

    // Result register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            res_valid_reg <= pix_valid_reg;
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (res_load && pix_valid_reg)
        begin
            color_index_reg <= color_index_next;
        end
    end

    assign result_valid = res_valid_reg;
    assign color_index  = color_index_reg;

endmodule

`default_nettype wire

// File: rtl/npc_checker.sv
// Port-level checks of the nearest palette color block and their binding.
// Depends on npc_pkg for the palette size.
`default_nettype none

module npc_checker (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 pixel_stall,
    input  wire                 result_valid,
    input  wire                 result_stall,
    input  wire npc_pkg::idx_t  color_index
);
    import npc_pkg::*;

    // A stalled result stays offered.
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result_valid dropped while stalled");

    // A stalled result keeps its value.
    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(color_index))
        else $error("color_index changed while stalled");

    // Every result names a searched palette entry.
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> color_index < IDX_W'(NUM_COLORS))
        else $error("color_index beyond the palette");

    // Pixels back up only behind a stalled result.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_stall |-> result_valid && result_stall)
        else $error("pixel_stall without a stalled result");

endmodule

bind nearest_palette_color_rgb npc_checker u_npc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .pixel_stall  (pixel_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .color_index  (color_index)
);

`default_nettype wire

// File: sim/npc_tb_pkg.sv
// Palette table, nearest color predictor and result scoreboard for the
// nearest palette color testbench. Depends on npc_pkg for the port types and NUM_COLORS.

package npc_tb_pkg;

    // Palette rows as the testbench knows them; the last row is only searched
    // when the block is built with sixteen colors.
    localparam int BASIC_COLORS [16][3] = '{
        '{  0,   0,   0},
        '{ 62, 184,  73},
        '{116, 208, 125},
        '{ 89,  85, 224},
        '{128, 118, 241},
        '{185,  94,  81},
        '{101, 219, 239},
        '{219, 101,  89},
        '{255, 137, 125},
        '{204, 195,  94},
        '{222, 208, 135},
        '{ 58, 162,  65},
        '{183, 102, 181},
        '{204, 204, 204},
        '{255, 255, 255},
        '{ 44,  42, 112}
    };

    // Index of the closest palette row; the strict compare keeps the lowest
    // index when two rows are equally far.
    function automatic npc_pkg::idx_t nearest_color(input npc_pkg::chan_t r,
                                                    input npc_pkg::chan_t g,
                                                    input npc_pkg::chan_t b);
        int rows;
        int best;
        int min_sq;
        int sq_sum;
        int dr;
        int dg;
        int db;
        int i;
        rows = npc_pkg::NUM_COLORS;
        if (rows < 1)
            rows = 1;
        if (rows > 16)
            rows = 16;
        best   = 0;
        min_sq = 0;
        for (i = 0; i < rows; i++)
        begin
            dr     = int'(r) - BASIC_COLORS[i][0];
            dg     = int'(g) - BASIC_COLORS[i][1];
            db     = int'(b) - BASIC_COLORS[i][2];
            sq_sum = dr * dr + dg * dg + db * db;
            if (i == 0 || sq_sum < min_sq)
            begin
                min_sq = sq_sum;
                best   = i;
            end
        end
        return npc_pkg::idx_t'(best);
    endfunction

    // Holds the expected color indexes in request order and checks results.
    class color_index_scoreboard;
        npc_pkg::idx_t expected_q[$];
        int            mismatches;

        function new();
            mismatches = 0;
        endfunction

        // An accepted pixel request adds one expected index.
        function void note_pixel(input npc_pkg::chan_t r, input npc_pkg::chan_t g,
                                 input npc_pkg::chan_t b);
            expected_q.push_back(nearest_color(r, g, b));
        endfunction

        // An accepted result request is compared with the oldest expectation.
        function void check_index(input npc_pkg::idx_t got);
            npc_pkg::idx_t want;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result color_index=%0d with no pixel pending",
                             $time, got);
                return;
            end
            want = expected_q.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: color_index expected %0d, got %0d", $time, want, got);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // True when every result matched and none is still owed.
        function bit clean();
            if (expected_q.size() != 0)
                $display("%0d expected results never arrived", expected_q.size());
            return mismatches == 0 && expected_q.size() == 0;
        endfunction
    endclass

endpackage

// File: sim/tb.sv
// Top-level testbench of nearest_palette_color_rgb: drives pixel requests with
// random gaps and stalls, and checks every color index against the predictor.
// Depends on npc_pkg, npc_tb_pkg and the block's RTL.

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import npc_pkg::*;
    import npc_tb_pkg::*;

    localparam int RANDOM_PIXELS = 830;
    localparam int PRESSURE_AT   = 400;
    localparam int PRESSURE_HOLD = 120;
    localparam int DRAIN_CYCLES  = 8;
    localparam int IDLE_LIMIT    = 2000;

    logic   clk = 1'b0;
    logic   rst_n;
    logic   pixel_valid;
    logic   pixel_stall;
    chan_t  red;
    chan_t  green;
    chan_t  blue;
    logic   result_valid;
    logic   result_stall;
    idx_t   color_index;

    color_index_scoreboard sb;
    int     pixels_taken = 0;
    int     sender_burst = 0;
    int     idle_cycles  = 0;
    bit     pressure_request = 1'b0;

    nearest_palette_color_rgb u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .color_index  (color_index)
    );

    always #1 clk = ~clk;

    function automatic chan_t clamp_chan(input int v);
        if (v < 0)
            return 8'd0;
        if (v > 255)
            return 8'd255;
        return chan_t'(v);
    endfunction

    // Idle cycles before the next pixel: mostly none or short, a few long,
    // and now and then a burst of back-to-back pixels.
    function automatic int sender_gap();
        int pick;
        if (sender_burst > 0)
        begin
            sender_burst--;
            return 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 5)
        begin
            sender_burst = $urandom_range(20, 60);
            return 0;
        end
        if (pick < 60)
            return 0;
        if (pick < 85)
            return $urandom_range(1, 3);
        if (pick < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Offers one pixel request at the falling edge and holds it until taken.
    task automatic send_pixel(input chan_t r, input chan_t g, input chan_t b);
        int gap;
        gap = sender_gap();
        if (gap > 0)
        begin
            pixel_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        pixel_valid <= 1'b1;
        red         <= r;
        green       <= g;
        blue        <= b;
        do
            @(posedge clk);
        while (pixel_stall);
        sb.note_pixel(r, g, b);
        pixels_taken++;
        if (pixels_taken == PRESSURE_AT)
            pressure_request = 1'b1;
        @(negedge clk);
    endtask

    // Receiver: alternating open and stalled runs of random length, plus one
    // long hold-off so that the block fills and stalls its input.
    initial
    begin
        int  run_left;
        bit  run_stall;
        run_left     = 0;
        run_stall    = 1'b0;
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (pressure_request)
            begin
                pressure_request = 1'b0;
                run_stall        = 1'b1;
                run_left         = PRESSURE_HOLD;
            end
            else if (run_left == 0)
            begin
                run_stall = !run_stall;
                if (run_stall)
                begin
                    case ($urandom_range(0, 19))
                        0:       run_left = $urandom_range(15, 50);
                        1, 2, 3,
                        4, 5:    run_left = $urandom_range(3, 8);
                        default: run_left = $urandom_range(1, 2);
                    endcase
                end
                else
                begin
                    case ($urandom_range(0, 19))
                        0:       run_left = $urandom_range(150, 400);
                        1, 2, 3,
                        4:       run_left = $urandom_range(10, 40);
                        default: run_left = $urandom_range(1, 10);
                    endcase
                end
            end
            result_stall <= run_stall;
            run_left--;
        end
    end

    // Every accepted result request is checked against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            sb.check_index(color_index);
    end

    // Watchdog: ends the run when nothing moves on either side for too long.
    always @(posedge clk)
    begin
        if ((pixel_valid && !pixel_stall) || (result_valid && !result_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no request accepted for %0d cycles", $time, IDLE_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Stimulus: reset, directed pixels, then random pixels, then drain.
    initial
    begin
        int n;
        int k;
        int j;
        int ch;
        int px [3];
        sb          = new();
        rst_n       = 1'b0;
        pixel_valid = 1'b0;
        red         = 8'd0;
        green       = 8'd0;
        blue        = 8'd0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Every palette row exactly, black and white among them, and the row
        // that lies beyond the searched range.
        for (k = 0; k < 16; k++)
            send_pixel(chan_t'(BASIC_COLORS[k][0]), chan_t'(BASIC_COLORS[k][1]),
                       chan_t'(BASIC_COLORS[k][2]));
        // Corners of the color cube.
        send_pixel(8'd255, 8'd0,   8'd0);
        send_pixel(8'd0,   8'd255, 8'd0);
        send_pixel(8'd0,   8'd0,   8'd255);
        send_pixel(8'd255, 8'd255, 8'd0);
        send_pixel(8'd0,   8'd255, 8'd255);
        // Exact midpoints between two rows: equal distance, lower index wins.
        send_pixel(8'd60,  8'd173, 8'd69);
        send_pixel(8'd237, 8'd119, 8'd107);

        // Random pixels: uniform, close to a palette row, or halfway between two.
        for (n = 0; n < RANDOM_PIXELS; n++)
        begin
            case ($urandom_range(0, 9))
                5, 6, 7:
                begin
                    k = $urandom_range(0, 15);
                    for (ch = 0; ch < 3; ch++)
                        px[ch] = BASIC_COLORS[k][ch] + int'($urandom_range(0, 40)) - 20;
                end
                8, 9:
                begin
                    k = $urandom_range(0, 15);
                    j = $urandom_range(0, 15);
                    for (ch = 0; ch < 3; ch++)
                        px[ch] = (BASIC_COLORS[k][ch] + BASIC_COLORS[j][ch]
                                  + int'($urandom_range(0, 1))) / 2;
                end
                default:
                begin
                    for (ch = 0; ch < 3; ch++)
                        px[ch] = $urandom_range(0, 255);
                end
            endcase
            send_pixel(clamp_chan(px[0]), clamp_chan(px[1]), clamp_chan(px[2]));
        end
        pixel_valid <= 1'b0;

        // Wait for the outstanding results, then a drain period for strays.
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.clean())
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
